>>> src/wds_pkg.sv
package wds_pkg;

  // CORDIC datapath widths and iteration count.
  localparam int CW   = 42;
  localparam int ZW   = 28;
  localparam int ITER = 20;

  // Iterative divider widths.
  localparam int DW   = 64;
  localparam int DENW = 48;

  // Angles are degrees times 65536.
  localparam logic signed [ZW-1:0] DEG90  = 28'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 28'sd11796480;
  localparam logic signed [ZW-1:0] DEG360 = 28'sd23592960;

  // Start vector of the rotation: the CORDIC gain correction in Q30.
  localparam logic signed [CW-1:0] CORDIC_X0 = 42'sd652034048;

  // Reciprocal of 125 scaled by 2^53 and rounded up, read as three 17-bit digits.
  // Exact for dividends below 2^50.
  localparam logic [50:0] RECIP125 = 51'd72057594037928;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NEAR_SPEED = 3'd0;
  localparam logic [2:0] CFG_NEAR_TURN  = 3'd1;
  localparam logic [2:0] CFG_FAR_SPEED  = 3'd2;
  localparam logic [2:0] CFG_FAR_TURN   = 3'd3;
  localparam logic [2:0] CFG_ARRIVE     = 3'd4;
  localparam logic [2:0] CFG_LEAVE      = 3'd5;
  localparam logic [2:0] CFG_WIDE       = 3'd6;
  localparam logic [2:0] CFG_REVERSE    = 3'd7;

  typedef enum logic {
    CORDIC_ROT = 1'b0,
    CORDIC_VEC = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_req_t;

  // Arctangent of 2^-i in degrees times 65536.
  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 28'd2949120;
      5'd1:    v = 28'd1740967;
      5'd2:    v = 28'd919879;
      5'd3:    v = 28'd466945;
      5'd4:    v = 28'd234379;
      5'd5:    v = 28'd117304;
      5'd6:    v = 28'd58666;
      5'd7:    v = 28'd29335;
      5'd8:    v = 28'd14668;
      5'd9:    v = 28'd7334;
      5'd10:   v = 28'd3667;
      5'd11:   v = 28'd1833;
      5'd12:   v = 28'd917;
      5'd13:   v = 28'd458;
      5'd14:   v = 28'd229;
      5'd15:   v = 28'd115;
      5'd16:   v = 28'd57;
      5'd17:   v = 28'd29;
      5'd18:   v = 28'd14;
      5'd19:   v = 28'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a sign and magnitude quotient to 32 bits two's complement.
  function automatic logic signed [31:0] sat32(input logic neg, input logic [DW-1:0] mag);
    logic signed [31:0] r;
    if (!neg) begin
      r = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end else begin
      r = (mag > 64'h8000_0000) ? 32'sh8000_0000 : $signed(-mag[31:0]);
    end
    return r;
  endfunction

endpackage

>>> src/wds_cordic.sv
module wds_cordic
  import wds_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_req_t          req_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 done_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [4:0]           it_q;
  logic                 busy_q, done_q, zero_q;
  cordic_mode_e         mode_q;

  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 down;

  // One micro-rotation per cycle; rotation steers by the sign of z, vectoring by the sign of y.
  always_comb begin
    xs   = x_q >>> it_q;
    ys   = y_q >>> it_q;
    at   = $signed(atan_lut(it_q));
    down = (mode_q == CORDIC_ROT) ? (z_q >= 0) : (y_q <= 0);
  end

  // Control: iteration counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == 5'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        it_q <= it_q + 5'd1;
      end
    end
  end

  // Datapath: load with the vectoring half-plane fold, then iterate.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      zero_q <= (req_i.mode == CORDIC_VEC) && (x_i == 0) && (y_i == 0);
      if (req_i.mode == CORDIC_ROT) begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= z_i;
      end else if (x_i < 0) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= (y_i >= 0) ? DEG180 : -DEG180;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (down) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = zero_q ? '0 : x_q;
  assign z_o    = zero_q ? '0 : z_q;

endmodule

>>> src/wds_div.sv
module wds_div
  import wds_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] num_i,
  input  logic [DENW-1:0]      den_i,
  output logic                 done_o,
  output logic                 neg_o,
  output logic [DW-1:0]        mag_o
);

  logic [DW-1:0]   n_q, q_q;
  logic [DENW-1:0] d_q, r_q;
  logic            neg_q, busy_q, done_q;
  logic [6:0]      cnt_q;

  logic [DENW:0]   trial;
  logic            fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {r_q, n_q[DW-1]};
    fits  = trial >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 7'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DW-1];
      n_q   <= num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
      d_q   <= den_i;
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[DW-2:0], 1'b0};
      q_q <= {q_q[DW-2:0], fits};
      r_q <= fits ? DENW'(trial - {1'b0, d_q}) : trial[DENW-1:0];
    end
  end

  assign done_o = done_q;
  assign neg_o  = neg_q;
  assign mag_o  = q_q;

endmodule

>>> src/wds_wp_table.sv
module wds_wp_table
  import wds_pkg::*;
#(
  parameter int WAYPOINTS = 16,
  parameter int IW        = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [IW-1:0]        waddr_i,
  input  logic signed [32:0]   wlon_i,
  input  logic signed [31:0]   wlat_i,
  input  logic [IW-1:0]        raddr_i,
  output logic signed [32:0]   rlon_o,
  output logic signed [31:0]   rlat_o
);

  logic signed [32:0]   mem_lon [WAYPOINTS];
  logic signed [31:0]   mem_lat [WAYPOINTS];
  logic [WAYPOINTS-1:0] vld_q;
  logic signed [32:0]   rlon_q;
  logic signed [31:0]   rlat_q;
  logic                 rv_q;

  // Entry valid bits stand for the cleared table after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rv_q <= vld_q[raddr_i];
    end
  end

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_lon[waddr_i] <= wlon_i;
      mem_lat[waddr_i] <= wlat_i;
    end
    rlon_q <= mem_lon[raddr_i];
    rlat_q <= mem_lat[raddr_i];
  end

  assign rlon_o = rv_q ? rlon_q : '0;
  assign rlat_o = rv_q ? rlat_q : '0;

endmodule

>>> src/waypoint_differential_steering_core.sv
// Waypoint steering core. Load items (tuser 0) write one waypoint entry and go
// straight to the output state, where the zero-drive result is registered; a navigation
// item that is the pending reverse step goes there the same way with minus full scale
// drives, and one that targets an empty entry goes there after one table read. A full
// navigation item holds the input closed while one shared 20-step CORDIC unit runs the
// latitude cosine, the distance and the bearing, and one shared multiplier forms the
// scaled products. The drives are then scaled by 256/1000 (a reciprocal multiplication
// per drive), or, when a drive is large, one drive is scaled by the other through the
// bit-serial divider; when both drives are equal and large, both go to full scale.
// Reaching a waypoint reruns the distance. The input reopens once the result is
// registered; a result that waits in the output register delays only the end of the
// following item. The waypoint table reads as all zero straight after reset and needs
// no clearing pass.
module waypoint_differential_steering_core
  import wds_pkg::*;
#(
  parameter int WAYPOINTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // waypoint_slot, waypoint_lon, waypoint_lat, heading, position_lon, position_lat,
  // speed, turn_rate, zero pad
  input  logic [199:0] s_axis_tdata,
  // mode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_drive, right_drive, active_waypoint, zero pad
  output logic [71:0]  m_axis_tdata,
  // reversing
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int IW = (WAYPOINTS > 1) ? $clog2(WAYPOINTS) : 1;
  localparam int TW = $clog2(WAYPOINTS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_COS   = 5'd2;
  localparam logic [4:0] S_MX    = 5'd3;
  localparam logic [4:0] S_MX2   = 5'd4;
  localparam logic [4:0] S_MX3   = 5'd5;
  localparam logic [4:0] S_MY    = 5'd6;
  localparam logic [4:0] S_VEC   = 5'd7;
  localparam logic [4:0] S_LEN   = 5'd8;
  localparam logic [4:0] S_BEAR  = 5'd9;
  localparam logic [4:0] S_BWAIT = 5'd10;
  localparam logic [4:0] S_ANG1  = 5'd11;
  localparam logic [4:0] S_ANG2  = 5'd12;
  localparam logic [4:0] S_ANG3  = 5'd13;
  localparam logic [4:0] S_T1    = 5'd14;
  localparam logic [4:0] S_T2    = 5'd15;
  localparam logic [4:0] S_M1    = 5'd16;
  localparam logic [4:0] S_M2    = 5'd17;
  localparam logic [4:0] S_M3    = 5'd18;
  localparam logic [4:0] S_SC    = 5'd19;
  localparam logic [4:0] S_DIVL  = 5'd20;
  localparam logic [4:0] S_DIVR  = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;
  localparam logic [4:0] S_Q2    = 5'd23;
  localparam logic [4:0] S_Q1    = 5'd24;
  localparam logic [4:0] S_Q0    = 5'd25;
  localparam logic [4:0] S_QACC  = 5'd26;
  localparam logic [4:0] S_QEND  = 5'd27;

  localparam logic signed [56:0] BIG_DRIVE = 57'sd256000;
  localparam logic signed [31:0] FULL_POS  = 32'sd65536;
  localparam logic signed [31:0] FULL_NEG  = -32'sd65536;

  // Input fields.
  logic               in_mode;
  logic [3:0]         in_slot;
  logic signed [32:0] in_wlon, in_plon;
  logic signed [31:0] in_wlat, in_plat;
  logic [15:0]        in_heading;
  logic signed [23:0] in_speed, in_rate;

  assign in_mode    = s_axis_tuser[0];
  assign in_slot    = s_axis_tdata[3:0];
  assign in_wlon    = $signed(s_axis_tdata[36:4]);
  assign in_wlat    = $signed(s_axis_tdata[68:37]);
  assign in_heading = s_axis_tdata[84:69];
  assign in_plon    = $signed(s_axis_tdata[117:85]);
  assign in_plat    = $signed(s_axis_tdata[149:118]);
  assign in_speed   = $signed(s_axis_tdata[173:150]);
  assign in_rate    = $signed(s_axis_tdata[197:174]);

  // Configuration registers.
  logic [7:0]  near_speed_q, near_turn_q, far_speed_q, far_turn_q, wide_q, reverse_q;
  logic [15:0] arrive_q, leave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_speed_q <= 8'd40;
      near_turn_q  <= 8'd60;
      far_speed_q  <= 8'd20;
      far_turn_q   <= 8'd80;
      arrive_q     <= 16'd512;
      leave_q      <= 16'd768;
      wide_q       <= 8'd90;
      reverse_q    <= 8'd170;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NEAR_SPEED: near_speed_q <= cfg_data_i[7:0];
        CFG_NEAR_TURN:  near_turn_q  <= cfg_data_i[7:0];
        CFG_FAR_SPEED:  far_speed_q  <= cfg_data_i[7:0];
        CFG_FAR_TURN:   far_turn_q   <= cfg_data_i[7:0];
        CFG_ARRIVE:     arrive_q     <= cfg_data_i;
        CFG_LEAVE:      leave_q      <= cfg_data_i;
        CFG_WIDE:       wide_q       <= cfg_data_i[7:0];
        CFG_REVERSE:    reverse_q    <= cfg_data_i[7:0];
        default:        ;
      endcase
    end
  end

  // Control state.
  logic [4:0]    state_q, state_d;
  logic [TW-1:0] tgt_q, tgt_d;
  logic          arrived_q, arrived_d, rpend_q, rpend_d, second_q, second_d, side_q, side_d;
  logic          m_valid_q, m_valid_d;

  // Payload registers.
  logic signed [ZW-1:0] hdir_q, hdir_d, cz_q, cz_d, dst_q, dst_d, z_q, z_d, a_q, a_d;
  logic                 cneg_q, cneg_d, cw_q, cw_d, far_q, far_d, rev_q, rev_d;
  logic signed [32:0]   plon_q, plon_d;
  logic signed [31:0]   plat_q, plat_d;
  logic signed [23:0]   spd_q, spd_d, rate_q, rate_d;
  logic signed [33:0]   dlon_q, dlon_d;
  logic signed [32:0]   dlat_q, dlat_d;
  logic signed [17:0]   c16_q, c16_d;
  logic signed [CW-1:0] dx_q, dx_d;
  logic signed [43:0]   len_q, len_d;
  logic signed [44:0]   u_q, u_d;
  logic signed [46:0]   t1_q, t1_d;
  logic signed [25:0]   t2_q, t2_d;
  logic signed [55:0]   p1_q, p1_d;
  logic signed [56:0]   tl_q, tl_d, tr_q, tr_d;
  logic signed [31:0]   left_q, left_d, right_q, right_d;
  logic signed [65:0]   prod_q;
  logic [93:0]          acc_q, acc_d;
  logic [71:0]          m_data_q, m_data_d;
  logic                 m_user_q, m_user_d;

  // Shared multiplier and unit requests.
  logic signed [47:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [65:0]   prod_d;
  cordic_req_t          cr_req;
  logic signed [CW-1:0] cr_x, cr_y, cr_xo;
  logic signed [ZW-1:0] cr_z, cr_zo;
  logic                 cr_done;
  logic                 dv_start, dv_done, dv_neg;
  logic signed [DW-1:0] dv_num;
  logic [DENW-1:0]      dv_den;
  logic [DW-1:0]        dv_mag;

  // Table port.
  logic                 tb_we;
  logic signed [32:0]   tb_lon;
  logic signed [31:0]   tb_lat;

  logic                 s_acc;
  logic signed [23:0]   lat_deg;
  logic signed [ZW-1:0] lat_abs, dir_raw, zf, wl, rl, a_w;
  logic                 cwf, ent_ok;
  logic signed [33:0]   ent_lon;
  logic signed [32:0]   ent_lat;
  logic signed [43:0]   len_w;
  logic signed [46:0]   u3;
  logic [7:0]           kp, kt;
  logic signed [56:0]   p2;
  logic signed [ZW-1:0] a_pre;
  logic signed [DW-1:0] tl_hi, tr_hi;
  logic signed [56:0]   sc_src, sc_abs;
  logic                 sc_neg;
  logic [45:0]          sc_w;
  logic [40:0]          sc_quo;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign prod_d        = mul_a * mul_b;

  // Helper values that several states read.
  always_comb begin
    lat_deg = $signed(in_plat[31:8]);
    lat_abs = (lat_deg < 0) ? -ZW'(lat_deg) : ZW'(lat_deg);
    dir_raw = $signed({3'b0, in_heading, 9'b0}) + DEG90;
    ent_ok  = 32'(tgt_q) < WAYPOINTS;
    ent_lon = ent_ok ? 34'(tb_lon) : '0;
    ent_lat = ent_ok ? 33'(tb_lat) : '0;
    len_w   = $signed(prod_q[59:16]);
    zf      = (z_q > DEG180) ? DEG360 - z_q : z_q;
    cwf     = (z_q > DEG180) ? !cw_q : cw_q;
    a_pre   = (cwf ? zf : -zf) + DEG180;
    a_w     = (a_q > DEG180) ? a_q - DEG360 : a_q;
    wl      = $signed({4'b0, wide_q, 16'b0});
    rl      = $signed({4'b0, reverse_q, 16'b0});
    u3      = (47'(u_q) <<< 1) + 47'(u_q);
    kp      = far_q ? far_speed_q : near_speed_q;
    kt      = far_q ? far_turn_q : near_turn_q;
    p2      = 57'($signed(prod_q[55:0]));
    tl_hi   = DW'(tl_q) <<< 16;
    tr_hi   = DW'(tr_q) <<< 16;
    // Plain scaling: |drive| * 256 / 1000 is |drive| * 32 / 125; only the low 41 bits of |drive| are used.
    sc_src  = side_q ? tr_q : tl_q;
    sc_neg  = sc_src < 0;
    sc_abs  = sc_neg ? -sc_src : sc_src;
    sc_w    = {sc_abs[40:0], 5'b0};
    sc_quo  = acc_q[93:53];
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    tgt_d     = tgt_q;
    arrived_d = arrived_q;
    rpend_d   = rpend_q;
    second_d  = second_q;
    side_d    = side_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    hdir_d    = hdir_q;
    cz_d      = cz_q;
    cneg_d    = cneg_q;
    plon_d    = plon_q;
    plat_d    = plat_q;
    spd_d     = spd_q;
    rate_d    = rate_q;
    dlon_d    = dlon_q;
    dlat_d    = dlat_q;
    c16_d     = c16_q;
    dx_d      = dx_q;
    len_d     = len_q;
    dst_d     = dst_q;
    z_d       = z_q;
    cw_d      = cw_q;
    a_d       = a_q;
    far_d     = far_q;
    u_d       = u_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    p1_d      = p1_q;
    tl_d      = tl_q;
    tr_d      = tr_q;
    left_d    = left_q;
    right_d   = right_q;
    rev_d     = rev_q;
    acc_d     = acc_q;
    mul_a     = 48'(dlon_q);
    mul_b     = c16_q;
    cr_req    = '{start: 1'b0, mode: CORDIC_ROT};
    cr_x      = CORDIC_X0;
    cr_y      = '0;
    cr_z      = cz_q;
    dv_start  = 1'b0;
    dv_num    = tl_hi;
    dv_den    = DENW'(tr_q);
    tb_we     = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          rev_d   = 1'b0;
          left_d  = '0;
          right_d = '0;
          if (!in_mode) begin
            tb_we   = 32'(in_slot) < WAYPOINTS;
            state_d = S_OUT;
          end else if (rpend_q) begin
            left_d  = FULL_NEG;
            right_d = FULL_NEG;
            rev_d   = 1'b1;
            rpend_d = 1'b0;
            state_d = S_OUT;
          end else begin
            second_d = 1'b0;
            plon_d   = in_plon;
            plat_d   = in_plat;
            spd_d    = in_speed;
            rate_d   = in_rate;
            hdir_d   = (dir_raw >= DEG360) ? dir_raw - DEG360 : dir_raw;
            cneg_d   = lat_abs > DEG90;
            cz_d     = (lat_abs > DEG90) ? DEG180 - lat_abs : lat_abs;
            state_d  = S_RD;
          end
        end
      end
      S_RD: begin
        dlon_d = ent_lon - 34'(plon_q);
        dlat_d = ent_lat - 33'(plat_q);
        if (!second_q && ent_lon == 0 && ent_lat == 0) begin
          state_d = S_OUT;
        end else if (!second_q) begin
          cr_req  = '{start: 1'b1, mode: CORDIC_ROT};
          state_d = S_COS;
        end else begin
          state_d = S_MX;
        end
      end
      S_COS: begin
        if (cr_done) begin
          c16_d   = cneg_q ? -$signed(cr_xo[31:14]) : $signed(cr_xo[31:14]);
          state_d = S_MX;
        end
      end
      S_MX: begin
        mul_a   = 48'(dlon_q);
        mul_b   = c16_q;
        state_d = S_MX2;
      end
      S_MX2: begin
        mul_a   = 48'($signed(prod_q[51:16]));
        mul_b   = 18'sd111000;
        state_d = S_MX3;
      end
      S_MX3: begin
        dx_d    = $signed(prod_q[57:16]);
        mul_a   = 48'(dlat_q);
        mul_b   = 18'sd111000;
        state_d = S_MY;
      end
      S_MY: begin
        cr_req  = '{start: 1'b1, mode: CORDIC_VEC};
        cr_x    = dx_q;
        cr_y    = $signed(prod_q[57:16]);
        state_d = S_VEC;
      end
      S_VEC: begin
        mul_a = 48'(cr_xo);
        mul_b = 18'sd39797;
        if (cr_done) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        len_d   = len_w;
        state_d = S_BEAR;
        if (!second_q) begin
          if (len_w <= $signed({28'b0, arrive_q}) && !arrived_q) begin
            arrived_d = 1'b1;
            if (32'(tgt_q) < WAYPOINTS) begin
              tgt_d = tgt_q + TW'(1);
            end
            second_d = 1'b1;
            state_d  = S_RD;
          end else if (len_w >= $signed({28'b0, leave_q})) begin
            arrived_d = 1'b0;
          end
        end
      end
      S_BEAR: begin
        cr_req  = '{start: 1'b1, mode: CORDIC_VEC};
        cr_x    = -CW'(dlon_q);
        cr_y    = -CW'(dlat_q);
        state_d = S_BWAIT;
      end
      S_BWAIT: begin
        if (cr_done) begin
          if (cr_zo < 0) begin
            dst_d = cr_zo + DEG360;
          end else if (cr_zo >= DEG360) begin
            dst_d = cr_zo - DEG360;
          end else begin
            dst_d = cr_zo;
          end
          state_d = S_ANG1;
        end
      end
      S_ANG1: begin
        if (hdir_q > dst_q) begin
          z_d  = hdir_q - dst_q;
          cw_d = 1'b1;
        end else begin
          z_d  = dst_q - hdir_q;
          cw_d = 1'b0;
        end
        state_d = S_ANG2;
      end
      S_ANG2: begin
        a_d     = a_pre;
        state_d = S_ANG3;
      end
      S_ANG3: begin
        a_d   = a_w;
        far_d = (a_w > wl) || (a_w < -wl);
        if ((a_w > rl) || (a_w < -rl)) begin
          rpend_d = 1'b1;
        end
        state_d = S_T1;
      end
      S_T1: begin
        u_d     = 45'(len_q) - $signed({29'b0, leave_q});
        t2_d    = 26'(a_q >>> 9) - 26'(rate_q);
        state_d = S_T2;
      end
      S_T2: begin
        t1_d    = (u3 >>> 2) - 47'(spd_q);
        state_d = S_M1;
      end
      S_M1: begin
        mul_a   = 48'(t1_q);
        mul_b   = $signed({10'b0, kp});
        state_d = S_M2;
      end
      S_M2: begin
        p1_d    = $signed(prod_q[55:0]);
        mul_a   = 48'(t2_q);
        mul_b   = $signed({10'b0, kt});
        state_d = S_M3;
      end
      S_M3: begin
        if (len_q < $signed({28'b0, arrive_q})) begin
          tl_d = '0;
          tr_d = '0;
        end else begin
          tl_d = 57'(p1_q) + p2;
          tr_d = 57'(p1_q) - p2;
        end
        state_d = S_SC;
      end
      S_SC: begin
        if (tl_q > BIG_DRIVE || tr_q > BIG_DRIVE) begin
          if (tr_q > tl_q) begin
            right_d  = FULL_POS;
            dv_start = 1'b1;
            dv_num   = tl_hi;
            dv_den   = DENW'(tr_q);
            state_d  = S_DIVL;
          end else if (tr_q < tl_q) begin
            left_d   = FULL_POS;
            dv_start = 1'b1;
            dv_num   = tr_hi;
            dv_den   = DENW'(tl_q);
            state_d  = S_DIVR;
          end else begin
            left_d  = FULL_POS;
            right_d = FULL_POS;
            state_d = S_OUT;
          end
        end else begin
          side_d  = 1'b0;
          state_d = S_Q2;
        end
      end
      // Reciprocal multiplication, top digit first, accumulated Horner fashion.
      S_Q2: begin
        mul_a   = $signed({2'b0, sc_w});
        mul_b   = $signed({1'b0, RECIP125[50:34]});
        state_d = S_Q1;
      end
      S_Q1: begin
        acc_d   = 94'(prod_q[62:0]);
        mul_a   = $signed({2'b0, sc_w});
        mul_b   = $signed({1'b0, RECIP125[33:17]});
        state_d = S_Q0;
      end
      S_Q0: begin
        acc_d   = (acc_q << 17) + 94'(prod_q[62:0]);
        mul_a   = $signed({2'b0, sc_w});
        mul_b   = $signed({1'b0, RECIP125[16:0]});
        state_d = S_QACC;
      end
      S_QACC: begin
        acc_d   = (acc_q << 17) + 94'(prod_q[62:0]);
        state_d = S_QEND;
      end
      S_QEND: begin
        if (!side_q) begin
          left_d  = sat32(sc_neg, DW'(sc_quo));
          side_d  = 1'b1;
          state_d = S_Q2;
        end else begin
          right_d = sat32(sc_neg, DW'(sc_quo));
          state_d = S_OUT;
        end
      end
      S_DIVL: begin
        if (dv_done) begin
          left_d  = sat32(dv_neg, dv_mag);
          state_d = S_OUT;
        end
      end
      S_DIVR: begin
        if (dv_done) begin
          right_d = sat32(dv_neg, dv_mag);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b0, 5'(tgt_q), right_q, left_q};
          m_user_d  = rev_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tgt_q     <= '0;
      arrived_q <= 1'b0;
      rpend_q   <= 1'b0;
      second_q  <= 1'b0;
      side_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tgt_q     <= tgt_d;
      arrived_q <= arrived_d;
      rpend_q   <= rpend_d;
      second_q  <= second_d;
      side_q    <= side_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdir_q   <= hdir_d;
    cz_q     <= cz_d;
    cneg_q   <= cneg_d;
    plon_q   <= plon_d;
    plat_q   <= plat_d;
    spd_q    <= spd_d;
    rate_q   <= rate_d;
    dlon_q   <= dlon_d;
    dlat_q   <= dlat_d;
    c16_q    <= c16_d;
    dx_q     <= dx_d;
    len_q    <= len_d;
    dst_q    <= dst_d;
    z_q      <= z_d;
    cw_q     <= cw_d;
    a_q      <= a_d;
    far_q    <= far_d;
    u_q      <= u_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    p1_q     <= p1_d;
    tl_q     <= tl_d;
    tr_q     <= tr_d;
    left_q   <= left_d;
    right_q  <= right_d;
    rev_q    <= rev_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  wds_wp_table #(
    .WAYPOINTS(WAYPOINTS),
    .IW       (IW)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (tb_we),
    .waddr_i(IW'(in_slot)),
    .wlon_i (in_wlon),
    .wlat_i (in_wlat),
    .raddr_i(IW'(tgt_d)),
    .rlon_o (tb_lon),
    .rlat_o (tb_lat)
  );

  wds_cordic u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cr_req),
    .x_i   (cr_x),
    .y_i   (cr_y),
    .z_i   (cr_z),
    .done_o(cr_done),
    .x_o   (cr_xo),
    .z_o   (cr_zo)
  );

  wds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (dv_den),
    .done_o (dv_done),
    .neg_o  (dv_neg),
    .mag_o  (dv_mag)
  );

endmodule

>>> src/wds_checker.sv
module wds_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // Only one item is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again straight after an accepted item");

  // A reverse step always drives both sides at minus full scale.
  a_reverse_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[31:0] == 32'hFFFF_0000 && m_axis_tdata[63:32] == 32'hFFFF_0000)
    else $error("reverse result without minus full scale drives");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind waypoint_differential_steering_core wds_checker u_wds_checker (.*);
